>>> hdl/fisr_pkg.sv
// Shared constants and helpers for the reciprocal square root pipeline.
package fisr_pkg;

  localparam logic [31:0] RSQRT_MAGIC = 32'h5f3759df;
  localparam logic [31:0] FP_HALF     = 32'h3f000000;
  localparam logic [31:0] FP_ONE_HALF = 32'h3fc00000;
  localparam logic [31:0] CANON_NAN   = 32'h7fc00000;

  // register stages in each float unit
  localparam int OP_LAT     = 3;
  // input stage plus five float operations
  localparam int PIPE_DEPTH = 1 + 5 * OP_LAT;
  // y is needed up to the input of the last multiply
  localparam int Y_DEPTH    = 4 * OP_LAT;

  // count of leading zeros of a 48-bit word, 48 for zero
  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    logic       found;
    n     = 6'd48;
    found = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!found && v[i]) begin
        n     = 6'(47 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

>>> hdl/fisr_in_if.sv
// Operand channel: valid/ready handshake carrying one float operand word.
interface fisr_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] value_bits;

  modport source (output valid, output value_bits, input ready);
  modport sink   (input valid, input value_bits, output ready);
endinterface

>>> hdl/fisr_out_if.sv
// Result channel: valid/ready handshake carrying one float result word.
interface fisr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] inv_sqrt_bits;

  modport source (output valid, output inv_sqrt_bits, input ready);
  modport sink   (input valid, input inv_sqrt_bits, output ready);
endinterface

>>> hdl/fisr_fmul.sv
// Three-stage single-precision multiplier, round to nearest even, subnormals kept.
module fisr_fmul (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] p
);
  import fisr_pkg::*;

  logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [7:0]  ea, eb;
  logic [23:0] ma, mb;

  // stage 1: unpack and multiply
  logic        s1_sign, s1_nan, s1_inf, s1_zero;
  logic [47:0] s1_prod;
  logic signed [9:0] s1_e0;

  always_comb begin
    a_nan  = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
    b_nan  = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
    a_inf  = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
    b_inf  = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    ea     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma     = {a[30:23] != 8'd0, a[22:0]};
    mb     = {b[30:23] != 8'd0, b[22:0]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sign <= a[31] ^ b[31];
      s1_nan  <= a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
      s1_inf  <= a_inf | b_inf;
      s1_zero <= a_zero | b_zero;
      s1_prod <= ma * mb;
      s1_e0   <= $signed({2'b00, ea}) + $signed({2'b00, eb}) - 10'sd126;
    end
  end

  // stage 2: normalize, or denormalize into the subnormal range
  logic [5:0]        lz;
  logic signed [9:0] e_norm, shr;
  logic [47:0]       n, mask;
  logic              sh_sticky;
  logic [7:0]        efield;
  logic              ovf;

  always_comb begin
    lz        = lzc48(s1_prod);
    e_norm    = s1_e0 - $signed({4'b0000, lz});
    n         = s1_prod;
    sh_sticky = 1'b0;
    shr       = 10'sd0;
    mask      = '0;
    ovf       = (e_norm >= 10'sd255);
    efield    = 8'd0;
    if (e_norm >= 10'sd1) begin
      n      = s1_prod << lz;
      efield = e_norm[7:0];
    end else if (s1_e0 >= 10'sd1) begin
      // subnormal result shares the scale of exponent field one
      n = s1_prod << (s1_e0[5:0] - 6'd1);
    end else begin
      shr = 10'sd1 - s1_e0;
      if (shr >= 10'sd48) begin
        n         = '0;
        sh_sticky = |s1_prod;
      end else begin
        mask      = (48'd1 << shr[5:0]) - 48'd1;
        n         = s1_prod >> shr[5:0];
        sh_sticky = |(s1_prod & mask);
      end
    end
  end

  logic        s2_sign, s2_nan, s2_inf, s2_zero, s2_ovf, s2_g, s2_st;
  logic [7:0]  s2_efield;
  logic [23:0] s2_m;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sign   <= s1_sign;
      s2_nan    <= s1_nan;
      s2_inf    <= s1_inf;
      s2_zero   <= s1_zero;
      s2_ovf    <= ovf;
      s2_efield <= efield;
      s2_m      <= n[47:24];
      s2_g      <= n[23];
      s2_st     <= (|n[22:0]) | sh_sticky;
    end
  end

  // stage 3: round and pack; a mantissa carry bumps the exponent
  logic [30:0] mag;
  logic [31:0] packed_w;

  always_comb begin
    mag = {s2_efield, s2_m[22:0]} + {30'd0, s2_g & (s2_st | s2_m[0])};
    priority if (s2_nan)          packed_w = CANON_NAN;
    else if (s2_inf || s2_ovf)    packed_w = {s2_sign, 8'hff, 23'd0};
    else if (s2_zero)             packed_w = {s2_sign, 31'd0};
    else                          packed_w = {s2_sign, mag};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= packed_w;
    end
  end

endmodule

>>> hdl/fisr_fadd.sv
// Three-stage single-precision adder, round to nearest even, subnormals kept.
module fisr_fadd (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] s
);
  import fisr_pkg::*;

  logic        a_nan, b_nan, a_inf, b_inf, swap;
  logic [31:0] big, sml;
  logic [7:0]  e_big, e_sml;

  // stage 1: unpack and order by magnitude
  logic        s1_nan, s1_inf, s1_inf_sign, s1_sign, s1_sub, s1_zsign;
  logic [7:0]  s1_d, s1_e;
  logic [23:0] s1_mb, s1_ms;

  always_comb begin
    a_nan = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
    b_nan = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
    a_inf = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
    b_inf = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
    swap  = b[30:0] > a[30:0];
    big   = swap ? b : a;
    sml   = swap ? a : b;
    e_big = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    e_sml = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_nan      <= a_nan | b_nan | (a_inf & b_inf & (a[31] ^ b[31]));
      s1_inf      <= a_inf | b_inf;
      s1_inf_sign <= a_inf ? a[31] : b[31];
      s1_sign     <= big[31];
      s1_sub      <= a[31] ^ b[31];
      // exact zero sum: negative only when both operands are negative
      s1_zsign    <= a[31] & b[31];
      s1_d        <= e_big - e_sml;
      s1_e        <= e_big;
      s1_mb       <= {big[30:23] != 8'd0, big[22:0]};
      s1_ms       <= {sml[30:23] != 8'd0, sml[22:0]};
    end
  end

  // stage 2: align the smaller operand and add or subtract
  logic [26:0] al, xs, mask;
  logic        st;
  logic [27:0] sum;

  always_comb begin
    xs   = {s1_ms, 3'b000};
    mask = '0;
    if (s1_d >= 8'd27) begin
      al = '0;
      st = |s1_ms;
    end else begin
      mask = (27'd1 << s1_d[4:0]) - 27'd1;
      al   = xs >> s1_d[4:0];
      st   = |(xs & mask);
    end
    al[0] = al[0] | st;
    if (s1_sub) sum = {1'b0, s1_mb, 3'b000} - {1'b0, al};
    else        sum = {1'b0, s1_mb, 3'b000} + {1'b0, al};
  end

  logic        s2_nan, s2_inf, s2_inf_sign, s2_sign, s2_zsign;
  logic [7:0]  s2_e;
  logic [27:0] s2_sum;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_nan      <= s1_nan;
      s2_inf      <= s1_inf;
      s2_inf_sign <= s1_inf_sign;
      s2_sign     <= s1_sign;
      s2_zsign    <= s1_zsign;
      s2_e        <= s1_e;
      s2_sum      <= sum;
    end
  end

  // stage 3: normalize, round and pack
  logic [5:0]  lz;
  logic [26:0] n;
  logic [9:0]  e_res;
  logic [7:0]  efield;
  logic [30:0] mag;
  logic [31:0] packed_w;

  always_comb begin
    // pad with ones so the count never runs past the 27 live bits
    lz     = lzc48({s2_sum[26:0], 21'h1fffff});
    efield = 8'd0;
    if (s2_sum[27]) begin
      n     = {s2_sum[27:2], s2_sum[1] | s2_sum[0]};
      e_res = {2'b00, s2_e} + 10'd1;
    end else if ({2'b00, lz} < {2'b00, s2_e}) begin
      n     = s2_sum[26:0] << lz;
      e_res = {2'b00, s2_e} - {4'b0000, lz};
    end else begin
      n     = s2_sum[26:0] << (s2_e - 8'd1);
      e_res = 10'd0;
    end
    if (e_res < 10'd255) efield = e_res[7:0];
    mag = {efield, n[25:3]} + {30'd0, n[2] & ((n[1] | n[0]) | n[3])};
    priority if (s2_nan)           packed_w = CANON_NAN;
    else if (s2_inf)               packed_w = {s2_inf_sign, 8'hff, 23'd0};
    else if (e_res >= 10'd255)     packed_w = {s2_sign, 8'hff, 23'd0};
    else if (s2_sum == 28'd0)      packed_w = {s2_zsign, 31'd0};
    else                           packed_w = {s2_sign, mag};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s <= packed_w;
    end
  end

endmodule

>>> hdl/fast_inverse_sqrt_core.sv
// Approximate reciprocal square root: integer initial guess plus one Newton step.
// Takes one single-precision word per clock and returns y*(1.5 - (x/2)*y*y), where
// y = 0x5f3759df - (x >>> 1), each float operation rounded to nearest even in that
// order; NaN results come out as 0x7fc00000. The pipeline is one input stage
// and five float units (four multiplies, one add) of three register stages each.
// Throughput is one word per cycle; the whole pipeline holds when the result word
// is not taken, so nothing is dropped or repeated.
module fast_inverse_sqrt_core (
  input  logic       clk,
  input  logic       rst,
  fisr_in_if.sink    operand,
  fisr_out_if.source result
);
  import fisr_pkg::*;

  logic                  en;
  logic [PIPE_DEPTH-1:0] vld;
  logic [31:0]           x0, y0;
  logic [31:0]           ydl [Y_DEPTH];
  logic [31:0]           hx, t1, t2, t3, r;

  assign en            = !vld[PIPE_DEPTH-1] || result.ready;
  assign operand.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_DEPTH-2:0], operand.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0 <= operand.value_bits;
      y0 <= RSQRT_MAGIC - {operand.value_bits[31], operand.value_bits[31:1]};
      ydl[0] <= y0;
      for (int i = 1; i < Y_DEPTH; i++) begin
        ydl[i] <= ydl[i-1];
      end
    end
  end

  fisr_fmul u_mul_hx (.clk, .en, .a(x0), .b(FP_HALF), .p(hx));
  fisr_fmul u_mul_t1 (.clk, .en, .a(hx), .b(ydl[OP_LAT-1]), .p(t1));
  fisr_fmul u_mul_t2 (.clk, .en, .a(t1), .b(ydl[2*OP_LAT-1]), .p(t2));
  fisr_fadd u_sub_t3 (.clk, .en, .a(FP_ONE_HALF), .b({~t2[31], t2[30:0]}), .s(t3));
  fisr_fmul u_mul_r  (.clk, .en, .a(ydl[Y_DEPTH-1]), .b(t3), .p(r));

  assign result.valid         = vld[PIPE_DEPTH-1];
  assign result.inv_sqrt_bits = r;

endmodule

>>> dv/fast_inverse_sqrt_core_tb.sv
// Testbench for the reciprocal square root core: bit-exact float predictor and stream checks.
`timescale 1ns / 100ps

module fast_inverse_sqrt_core_tb;
  import fisr_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 200;

  logic clk;
  logic rst;

  fisr_in_if  operand_ch ();
  fisr_out_if result_ch ();

  fast_inverse_sqrt_core DUT (
    .clk    (clk),
    .rst    (rst),
    .operand(operand_ch),
    .result (result_ch)
  );

  logic [31:0] operand_queue[$];
  logic [31:0] expected_rsqrt[$];
  int          send_idle_pct;
  int          recv_stall_pct;
  bit          hold_req;
  int          hold_cnt;
  int          idle_cycles;
  int          mismatches;
  int          sent_cnt;
  int          got_cnt;
  bit          timed_out;

  // ---------------------------------------------------------------------------
  // Single-precision arithmetic, round to nearest even, subnormals kept.
  // A finite value is carried as sig * 2^expo.

  function automatic bit is_nan(logic [31:0] a);
    return a[30:23] == 8'hff && a[22:0] != 0;
  endfunction

  function automatic bit is_inf(logic [31:0] a);
    return a[30:23] == 8'hff && a[22:0] == 0;
  endfunction

  function automatic void split(input logic [31:0] a, output logic [299:0] sig,
                                output int expo);
    if (a[30:23] == 0) begin
      sig  = 300'(a[22:0]);
      expo = -149;
    end else begin
      sig  = 300'({1'b1, a[22:0]});
      expo = int'(a[30:23]) - 150;
    end
  endfunction

  function automatic logic [31:0] round_pack(logic sgn, logic [299:0] sig, int expo);
    int          msb;
    int          sh;
    int          lsb_exp;
    logic [299:0] m;
    logic [299:0] rem;
    logic [299:0] halfway;
    if (sig == 0) return {sgn, 31'd0};
    msb = 0;
    for (int i = 0; i < 300; i++) if (sig[i]) msb = i;
    sh = msb - 23;
    if (expo + sh < -149) sh = -149 - expo;
    if (sh <= 0) begin
      m = sig << (-sh);
    end else begin
      m       = sig >> sh;
      rem     = sig & ((300'd1 << sh) - 1);
      halfway = 300'd1 << (sh - 1);
      if (rem > halfway || (rem == halfway && m[0])) m = m + 1;
    end
    lsb_exp = expo + sh;
    if (m[24]) begin
      m       = m >> 1;
      lsb_exp = lsb_exp + 1;
    end
    if (!m[23]) return {sgn, 8'd0, m[22:0]};
    if (lsb_exp + 150 >= 255) return {sgn, 8'hff, 23'd0};
    return {sgn, 8'(lsb_exp + 150), m[22:0]};
  endfunction

  function automatic logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
    logic [299:0] sa;
    logic [299:0] sb;
    int           ea;
    int           eb;
    logic         sgn;
    sgn = a[31] ^ b[31];
    if (is_nan(a) || is_nan(b)) return CANON_NAN;
    if (is_inf(a) || is_inf(b)) begin
      if (a[30:0] == 0 || b[30:0] == 0) return CANON_NAN;
      return {sgn, 8'hff, 23'd0};
    end
    split(a, sa, ea);
    split(b, sb, eb);
    return round_pack(sgn, sa * sb, ea + eb);
  endfunction

  function automatic logic [31:0] fadd(logic [31:0] a, logic [31:0] b);
    logic [299:0] sa;
    logic [299:0] sb;
    int           ea;
    int           eb;
    int           emin;
    if (is_nan(a) || is_nan(b)) return CANON_NAN;
    if (is_inf(a) && is_inf(b)) return (a[31] != b[31]) ? CANON_NAN : a;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    split(a, sa, ea);
    split(b, sb, eb);
    emin = (ea < eb) ? ea : eb;
    sa   = sa << (ea - emin);
    sb   = sb << (eb - emin);
    if (a[31] == b[31]) return round_pack(a[31], sa + sb, emin);
    if (sa == sb) return 32'd0;
    if (sa > sb) return round_pack(a[31], sa - sb, emin);
    return round_pack(b[31], sb - sa, emin);
  endfunction

  // initial guess from the integer trick, then one Newton step
  function automatic logic [31:0] rsqrt_estimate(logic [31:0] x);
    logic [31:0] y;
    logic [31:0] hx;
    logic [31:0] t2;
    logic [31:0] r;
    y  = RSQRT_MAGIC - {x[31], x[31:1]};
    hx = fmul(x, FP_HALF);
    t2 = fmul(fmul(hx, y), y);
    r  = fmul(y, fadd(FP_ONE_HALF, {~t2[31], t2[30:0]}));
    return is_nan(r) ? CANON_NAN : r;
  endfunction

  // ---------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // operand driver; predict each word as it is accepted
  always @(posedge clk) begin
    if (rst) begin
      operand_ch.valid      <= 1'b0;
      operand_ch.value_bits <= '0;
    end else begin
      if (operand_ch.valid && operand_ch.ready) begin
        expected_rsqrt.push_back(rsqrt_estimate(operand_ch.value_bits));
        sent_cnt <= sent_cnt + 1;
      end
      if (!operand_ch.valid || operand_ch.ready) begin
        if (operand_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          operand_ch.valid      <= 1'b1;
          operand_ch.value_bits <= operand_queue.pop_front();
        end else begin
          operand_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result ready, with an optional long hold-off counted here
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      hold_cnt        <= 0;
    end else if (hold_req && hold_cnt < LONG_HOLD) begin
      result_ch.ready <= 1'b0;
      hold_cnt        <= hold_cnt + 1;
    end else begin
      if (!hold_req) hold_cnt <= 0;
      result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result monitor and watchdog
  always @(posedge clk) begin
    logic [31:0] want;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        got_cnt <= got_cnt + 1;
        if (expected_rsqrt.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual %08h", $time,
                   result_ch.inv_sqrt_bits);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_rsqrt.pop_front();
          if (result_ch.inv_sqrt_bits !== want) begin
            $display("%0t: inv_sqrt_bits expected %08h, actual %08h", $time, want,
                     result_ch.inv_sqrt_bits);
            mismatches <= mismatches + 1;
          end
        end
      end
      if ((result_ch.valid && result_ch.ready) || (operand_ch.valid && operand_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time,
                 expected_rsqrt.size());
        $display("fast_inverse_sqrt_core: mismatch");
        $finish;
      end
    end
  end

  function automatic logic [31:0] random_operand();
    logic [31:0] v;
    int          kind;
    v    = $urandom();
    kind = $urandom_range(9);
    case (kind)
      4, 5, 6: begin
        v[31]    = 1'b0;
        v[30:23] = 8'($urandom_range(160, 100));
      end
      7: v[30:23] = 8'd0;
      8: v[30:23] = 8'hff;
      9: v[30:23] = $urandom_range(1) ? 8'($urandom_range(254, 250)) : 8'($urandom_range(3, 1));
      default: ;
    endcase
    return v;
  endfunction

  task automatic drain();
    while (operand_queue.size() > 0 || operand_ch.valid || expected_rsqrt.size() > 0)
      @(posedge clk);
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, int count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) operand_queue.push_back(random_operand());
    drain();
  endtask

  initial begin
    logic [31:0] corner[$];
    rst            = 1'b1;
    hold_req       = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    mismatches     = 0;
    sent_cnt       = 0;
    got_cnt        = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // zeros, infinities, NaNs, subnormals, extremes, negatives, exact powers
    corner = '{32'h00000000, 32'h80000000, 32'h7f800000, 32'hff800000, 32'h7fc00000,
               32'h7f800001, 32'hffffffff, 32'h00000001, 32'h00000002, 32'h007fffff,
               32'h00800000, 32'h3f800000, 32'h40800000, 32'h3e800000, 32'h3fc00000,
               32'h41200000, 32'h7f7fffff, 32'h80000001, 32'hbf800000, 32'h5f3759df,
               32'h7fffffff, 32'h80800000};
    foreach (corner[i]) operand_queue.push_back(corner[i]);
    drain();

    run_phase(0, 0, 110);
    run_phase(76, 0, 90);
    run_phase(0, 76, 90);
    run_phase(16, 16, 110);

    // hold the result side off while operands keep coming; the pipe must fill and stall
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b1;
    for (int i = 0; i < 60; i++) operand_queue.push_back(random_operand());
    while (hold_cnt < LONG_HOLD) @(posedge clk);
    hold_req = 1'b0;
    drain();

    repeat (3 * PIPE_DEPTH) @(posedge clk);
    $display("Covered %0d operands (corners, random floats, NaN/Inf/subnormal/negative)",
             sent_cnt);
    $display("under idle/stall mixes and a %0d-cycle result hold-off; %0d results checked",
             LONG_HOLD, got_cnt);
    if (mismatches == 0 && expected_rsqrt.size() == 0) begin
      $display("fast_inverse_sqrt_core: match");
    end else begin
      $display("fast_inverse_sqrt_core: mismatch");
    end
    $finish;
  end

endmodule

>>> fast_inverse_sqrt_core.f
hdl/fisr_pkg.sv
hdl/fisr_in_if.sv
hdl/fisr_out_if.sv
hdl/fisr_fmul.sv
hdl/fisr_fadd.sv
hdl/fast_inverse_sqrt_core.sv
dv/fast_inverse_sqrt_core_tb.sv
